// ===== src/pfps_pkg.sv =====
// Shared types and constants for the packed FFT power spectrum block.
// No dependencies; every other file imports this package.
package pfps_pkg;

  // Sideband that travels with every word down the pipeline.
  typedef struct packed {
    logic [8:0] bin;
    logic       last;
  } pfps_tag_t;

  // Configuration register indexes.
  typedef logic [0:0] reg_index_t;
  localparam reg_index_t REG_POWER_MODE = 1'd0;
  localparam reg_index_t REG_LOG_MODE   = 1'd1;

  localparam int ISQRT_STEPS   = 32;
  localparam int LOG_FRAC_BITS = 40;
  localparam int LG_W          = 46;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

  function automatic logic [31:0] abs32(input logic signed [31:0] w);
    abs32 = w[31] ? (32'd0 - 32'(w)) : 32'(w);
  endfunction

endpackage

// ===== src/pfps_square.sv =====
// Input side: splits the DC/Nyquist pair into two words and forms re^2 + im^2.
// Depends on pfps_pkg.
module pfps_square import pfps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [7:0]         pair_index,
  input  logic signed [31:0] word_even,
  input  logic signed [31:0] word_odd,
  input  logic [8:0]         nyq_bin,
  output logic               busy,
  output logic               out_valid,
  output pfps_tag_t          out_tag,
  output logic [63:0]        out_power
);

  logic        pending;
  logic [31:0] held_odd;
  logic        accept;
  logic        s1_valid, s2_valid;
  pfps_tag_t   s1_tag, s2_tag;
  logic [31:0] s1_a, s1_b;
  logic [63:0] sq_a, sq_b;

  assign busy   = pending;
  assign accept = start && !pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pending   <= accept && (pair_index == 8'd0);
      s1_valid  <= accept || pending;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_odd <= word_odd;
    end
    // The Nyquist word goes in the cycle after the DC word.
    if (pending) begin
      s1_a       <= abs32(held_odd);
      s1_b       <= 32'd0;
      s1_tag.bin <= nyq_bin;
      s1_tag.last <= 1'b1;
    end else begin
      s1_a        <= abs32(word_even);
      s1_b        <= (pair_index == 8'd0) ? 32'd0 : abs32(word_odd);
      s1_tag.bin  <= {1'b0, pair_index};
      s1_tag.last <= (pair_index != 8'd0);
    end
    sq_a      <= 64'(s1_a) * 64'(s1_a);
    sq_b      <= 64'(s1_b) * 64'(s1_b);
    s2_tag    <= s1_tag;
    out_power <= sq_a + sq_b;
    out_tag   <= s2_tag;
  end

endmodule

// ===== src/pfps_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, then mode select.
// Depends on pfps_pkg.
module pfps_isqrt import pfps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        power_mode,
  input  logic        in_valid,
  input  pfps_tag_t   in_tag,
  input  logic [63:0] in_power,
  output logic        out_valid,
  output pfps_tag_t   out_tag,
  output logic [63:0] out_value
);

  logic        st_valid [1:ISQRT_STEPS];
  pfps_tag_t   st_tag   [1:ISQRT_STEPS];
  logic [63:0] st_x     [1:ISQRT_STEPS];
  logic [63:0] st_res   [1:ISQRT_STEPS];
  logic [63:0] st_pw    [1:ISQRT_STEPS];

  for (genvar i = 0; i < ISQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic        cur_valid;
    pfps_tag_t   cur_tag;
    logic [63:0] cur_x, cur_res, cur_pw, trial;

    if (i == 0) begin : g_first
      assign cur_valid = in_valid;
      assign cur_tag   = in_tag;
      assign cur_x     = in_power;
      assign cur_res   = 64'd0;
      assign cur_pw    = in_power;
    end else begin : g_rest
      assign cur_valid = st_valid[i];
      assign cur_tag   = st_tag[i];
      assign cur_x     = st_x[i];
      assign cur_res   = st_res[i];
      assign cur_pw    = st_pw[i];
    end

    assign trial = cur_res + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i+1] <= 1'b0;
      end else begin
        st_valid[i+1] <= cur_valid;
      end
      st_tag[i+1] <= cur_tag;
      st_pw[i+1]  <= cur_pw;
      if (cur_x >= trial) begin
        st_x[i+1]   <= cur_x - trial;
        st_res[i+1] <= (cur_res >> 1) + BIT;
      end else begin
        st_x[i+1]   <= cur_x;
        st_res[i+1] <= cur_res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= st_valid[ISQRT_STEPS];
    end
    out_tag   <= st_tag[ISQRT_STEPS];
    out_value <= power_mode ? st_pw[ISQRT_STEPS] : st_res[ISQRT_STEPS];
  end

endmodule

// ===== src/pfps_ln.sv =====
// Pipelined Q16 natural log: normalize, forty squaring steps, scale by ln 2.
// Depends on pfps_pkg.
module pfps_ln import pfps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        log_mode,
  input  logic        in_valid,
  input  pfps_tag_t   in_tag,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output pfps_tag_t   out_tag,
  output logic [63:0] out_value
);

  localparam int NORM_STAGES = 3;

  // Floor to one.
  logic        n0_valid;
  pfps_tag_t   n0_tag;
  logic [63:0] n0_v, n0_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      n0_valid <= 1'b0;
    end else begin
      n0_valid <= in_valid;
    end
    n0_tag <= in_tag;
    n0_v   <= in_value;
    n0_w   <= (in_value == 64'd0) ? 64'd1 : in_value;
  end

  // Normalize: two shift steps per stage, 32/16, 8/4, 2/1.
  logic        nm_valid [1:NORM_STAGES];
  pfps_tag_t   nm_tag   [1:NORM_STAGES];
  logic [63:0] nm_v     [1:NORM_STAGES];
  logic [63:0] nm_w     [1:NORM_STAGES];
  logic [5:0]  nm_lz    [1:NORM_STAGES];

  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    localparam int SA = 32 >> (2 * j);
    localparam int SB = SA / 2;
    logic        cur_valid;
    pfps_tag_t   cur_tag;
    logic [63:0] cur_v, cur_w, mid_w, end_w;
    logic [5:0]  cur_lz, mid_lz, end_lz;

    if (j == 0) begin : g_first
      assign cur_valid = n0_valid;
      assign cur_tag   = n0_tag;
      assign cur_v     = n0_v;
      assign cur_w     = n0_w;
      assign cur_lz    = 6'd0;
    end else begin : g_rest
      assign cur_valid = nm_valid[j];
      assign cur_tag   = nm_tag[j];
      assign cur_v     = nm_v[j];
      assign cur_w     = nm_w[j];
      assign cur_lz    = nm_lz[j];
    end

    always_comb begin
      if (cur_w[63 -: SA] == '0) begin
        mid_w  = cur_w << SA;
        mid_lz = cur_lz + 6'(SA);
      end else begin
        mid_w  = cur_w;
        mid_lz = cur_lz;
      end
      if (mid_w[63 -: SB] == '0) begin
        end_w  = mid_w << SB;
        end_lz = mid_lz + 6'(SB);
      end else begin
        end_w  = mid_w;
        end_lz = mid_lz;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nm_valid[j+1] <= 1'b0;
      end else begin
        nm_valid[j+1] <= cur_valid;
      end
      nm_tag[j+1] <= cur_tag;
      nm_v[j+1]   <= cur_v;
      nm_w[j+1]   <= end_w;
      nm_lz[j+1]  <= end_lz;
    end
  end

  // Squaring steps: stage A forms partial products, stage B sums and tests.
  logic             sa_valid [0:LOG_FRAC_BITS-1];
  pfps_tag_t        sa_tag   [0:LOG_FRAC_BITS-1];
  logic [63:0]      sa_v     [0:LOG_FRAC_BITS-1];
  logic [LG_W-1:0]  sa_lg    [0:LOG_FRAC_BITS-1];
  logic [61:0]      sa_p11   [0:LOG_FRAC_BITS-1];
  logic [62:0]      sa_p01   [0:LOG_FRAC_BITS-1];
  logic [63:0]      sa_p00   [0:LOG_FRAC_BITS-1];
  logic             sb_valid [1:LOG_FRAC_BITS];
  pfps_tag_t        sb_tag   [1:LOG_FRAC_BITS];
  logic [63:0]      sb_v     [1:LOG_FRAC_BITS];
  logic [LG_W-1:0]  sb_lg    [1:LOG_FRAC_BITS];
  logic [63:0]      sb_m     [1:LOG_FRAC_BITS];

  for (genvar i = 0; i < LOG_FRAC_BITS; i++) begin : g_sq
    logic            cur_valid;
    pfps_tag_t       cur_tag;
    logic [63:0]     cur_v, cur_m;
    logic [LG_W-1:0] cur_lg;
    logic [127:0]    sq;
    logic [63:0]     m2;

    if (i == 0) begin : g_first
      assign cur_valid = nm_valid[NORM_STAGES];
      assign cur_tag   = nm_tag[NORM_STAGES];
      assign cur_v     = nm_v[NORM_STAGES];
      assign cur_m     = nm_w[NORM_STAGES] >> 1;
      assign cur_lg    = {6'd63 - nm_lz[NORM_STAGES], {LOG_FRAC_BITS{1'b0}}};
    end else begin : g_rest
      assign cur_valid = sb_valid[i];
      assign cur_tag   = sb_tag[i];
      assign cur_v     = sb_v[i];
      assign cur_m     = sb_m[i];
      assign cur_lg    = sb_lg[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sa_valid[i] <= 1'b0;
      end else begin
        sa_valid[i] <= cur_valid;
      end
      sa_tag[i] <= cur_tag;
      sa_v[i]   <= cur_v;
      sa_lg[i]  <= cur_lg;
      sa_p11[i] <= 62'(cur_m[62:32]) * 62'(cur_m[62:32]);
      sa_p01[i] <= 63'(cur_m[31:0]) * 63'(cur_m[62:32]);
      sa_p00[i] <= 64'(cur_m[31:0]) * 64'(cur_m[31:0]);
    end

    assign sq = ({66'd0, sa_p11[i]} << 64) + ({65'd0, sa_p01[i]} << 33)
              + {64'd0, sa_p00[i]};
    assign m2 = sq[125:62];

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_valid[i+1] <= 1'b0;
      end else begin
        sb_valid[i+1] <= sa_valid[i];
      end
      sb_tag[i+1] <= sa_tag[i];
      sb_v[i+1]   <= sa_v[i];
      if (m2[63]) begin
        sb_m[i+1]  <= m2 >> 1;
        sb_lg[i+1] <= sa_lg[i] | (LG_W'(1) << (LOG_FRAC_BITS - 1 - i));
      end else begin
        sb_m[i+1]  <= m2;
        sb_lg[i+1] <= sa_lg[i];
      end
    end
  end

  // Scale by ln 2 in Q64: four 23x32 partial products, then round.
  logic        mc_valid;
  pfps_tag_t   mc_tag;
  logic [63:0] mc_v;
  logic [54:0] pp00, pp01, pp10, pp11;
  logic [109:0] prod;
  logic [LG_W-1:0] lg_fin;

  assign lg_fin = sb_lg[LOG_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      mc_valid <= 1'b0;
    end else begin
      mc_valid <= sb_valid[LOG_FRAC_BITS];
    end
    mc_tag <= sb_tag[LOG_FRAC_BITS];
    mc_v   <= sb_v[LOG_FRAC_BITS];
    pp00   <= 55'(lg_fin[22:0])  * 55'(LN2_Q64[31:0]);
    pp01   <= 55'(lg_fin[22:0])  * 55'(LN2_Q64[63:32]);
    pp10   <= 55'(lg_fin[45:23]) * 55'(LN2_Q64[31:0]);
    pp11   <= 55'(lg_fin[45:23]) * 55'(LN2_Q64[63:32]);
  end

  assign prod = ({55'd0, pp11} << 55) + ({55'd0, pp01} << 32) + ({55'd0, pp10} << 23)
              + {55'd0, pp00} + (110'd1 << 87);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mc_valid;
    end
    out_tag   <= mc_tag;
    out_value <= log_mode ? {42'd0, prod[109:88]} : mc_v;
  end

endmodule

// ===== src/packed_fft_power_spectrum_top.sv =====
// Top level of the packed FFT power spectrum block: config registers and the
// three pipeline sections. Depends on pfps_pkg, pfps_square, pfps_isqrt, pfps_ln.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------
//   input     start / busy         pair_index, word_even, word_odd
//   result    result_strobe        bin_index, bin_value, last_of_run
//   config    cfg_we               cfg_index, cfg_data
//
// One word is taken per cycle while busy is low; pair 0 raises busy for a single cycle,
// the cycle after it is taken, while its Nyquist half enters the pipeline.
// Every result passes through the squaring section, the 32 square root stages,
// the log normalize stages, the 40 two-stage log squaring steps and the ln 2 scaling.
// rst (synchronous) clears the valid bits and sets power_mode 1, log_mode 0.
// The receiver cannot stall; results leave on the strobe and nothing holds.
module packed_fft_power_spectrum_top import pfps_pkg::*; #(
  parameter int FFT_SIZE = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         pair_index,
  input  logic signed [31:0] word_even,
  input  logic signed [31:0] word_odd,
  output logic               result_strobe,
  output logic [8:0]         bin_index,
  output logic [63:0]        bin_value,
  output logic               last_of_run,
  input  logic               cfg_we,
  input  reg_index_t         cfg_index,
  input  logic [0:0]         cfg_data
);

  // Nyquist bin keeps the low nine bits of FFT_SIZE/2.
  localparam logic [8:0] NYQ_BIN = 9'((FFT_SIZE / 2) % 512);

  logic power_mode, log_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_mode <= 1'b1;
      log_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWER_MODE: power_mode <= cfg_data[0];
        REG_LOG_MODE:   log_mode   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  logic        sq_valid, rt_valid, ln_valid;
  pfps_tag_t   sq_tag, rt_tag, ln_tag;
  logic [63:0] sq_power, rt_value;

  // Split pair 0 and square the words.
  pfps_square u_square (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .pair_index (pair_index),
    .word_even  (word_even),
    .word_odd   (word_odd),
    .nyq_bin    (NYQ_BIN),
    .busy       (busy),
    .out_valid  (sq_valid),
    .out_tag    (sq_tag),
    .out_power  (sq_power)
  );

  // Square root, or pass the power through, per power_mode.
  pfps_isqrt u_isqrt (
    .clk        (clk),
    .rst        (rst),
    .power_mode (power_mode),
    .in_valid   (sq_valid),
    .in_tag     (sq_tag),
    .in_power   (sq_power),
    .out_valid  (rt_valid),
    .out_tag    (rt_tag),
    .out_value  (rt_value)
  );

  // Q16 log, or pass the value through, per log_mode.
  pfps_ln u_ln (
    .clk       (clk),
    .rst       (rst),
    .log_mode  (log_mode),
    .in_valid  (rt_valid),
    .in_tag    (rt_tag),
    .in_value  (rt_value),
    .out_valid (ln_valid),
    .out_tag   (ln_tag),
    .out_value (bin_value)
  );

  assign result_strobe = ln_valid;
  assign bin_index     = ln_tag.bin;
  assign last_of_run   = ln_tag.last;

`ifndef SYNTHESIS
  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("busy held longer than one cycle");
  a_dc_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && pair_index == 8'd0) |=> busy)
    else $error("DC pair taken without busy");
  a_nyq_follows: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_of_run) |=>
      (result_strobe && last_of_run && bin_index == NYQ_BIN))
    else $error("Nyquist word does not follow DC word");
  a_dc_bin: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_of_run) |-> (bin_index == 9'd0))
    else $error("non-final word is not bin 0");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for packed_fft_power_spectrum_top: random and corner-case
// word pairs under every mode setting, checked against an in-bench model.
// Depends on pfps_pkg and the RTL under src.
module testbench;
  import pfps_pkg::*;

  typedef struct {
    logic [7:0]         pair;
    logic signed [31:0] even;
    logic signed [31:0] odd;
  } pair_word_t;

  typedef struct {
    logic [8:0]  bin;
    logic [63:0] value;
    logic        last;
  } bin_result_t;

  localparam int FFT_N = 512;
  localparam int DRAIN_CYCLES = 140;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         pair_index = '0;
  logic signed [31:0] word_even = '0;
  logic signed [31:0] word_odd = '0;
  logic               result_strobe;
  logic [8:0]         bin_index;
  logic [63:0]        bin_value;
  logic               last_of_run;
  logic               cfg_we = 1'b0;
  reg_index_t         cfg_index = REG_POWER_MODE;
  logic [0:0]         cfg_data = '0;

  pair_word_t  pending_words[$];
  bin_result_t expected_bins[$];
  logic        mode_power = 1'b1;
  logic        mode_log = 1'b0;
  int          idle_pct = 0;
  int          mismatches = 0;

  packed_fft_power_spectrum_top #(.FFT_SIZE(FFT_N)) dut (.*);

  always #4 clk = ~clk;

  // Bit-serial integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q16 natural log of max(v,1): log2 by repeated squaring, then scale by ln 2.
  function automatic logic [63:0] ln_fixed(input logic [63:0] v);
    int          k;
    logic [63:0] m;
    logic [63:0] lg;
    logic [127:0] prod;
    if (v == 0) v = 1;
    k = 0;
    for (int b = 0; b < 64; b++) if (v[b]) k = b;
    m = (k <= 62) ? (v << (62 - k)) : (v >> 1);
    lg = 64'(k) << LOG_FRAC_BITS;
    for (int i = 1; i <= LOG_FRAC_BITS; i++) begin
      prod = 128'(m) * 128'(m);
      m = prod[125:62];
      if (m[63]) begin
        lg[LOG_FRAC_BITS - i] = 1'b1;
        m = m >> 1;
      end
    end
    prod = 128'(lg) * 128'(LN2_Q64);
    return (prod[127:64] + (64'd1 << 23)) >> 24;
  endfunction

  function automatic logic [63:0] shape_power(input logic [63:0] pw);
    logic [63:0] v;
    v = mode_power ? pw : floor_sqrt(pw);
    if (mode_log) v = ln_fixed(v);
    return v;
  endfunction

  // Queue the bins one accepted word pair must produce.
  task automatic predict_bins(input pair_word_t w);
    logic [63:0] re;
    logic [63:0] im;
    re = 64'(abs32(w.even));
    im = 64'(abs32(w.odd));
    if (w.pair == 0) begin
      expected_bins.push_back('{9'd0, shape_power(re * re), 1'b0});
      expected_bins.push_back('{9'(FFT_N / 2), shape_power(im * im), 1'b1});
    end else begin
      expected_bins.push_back('{9'(w.pair), shape_power(re * re + im * im), 1'b1});
    end
  endtask

  // Driver: advance on accept, hold while busy, idle at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_bins(pending_words.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        pair_index <= pending_words[0].pair;
        word_even <= pending_words[0].even;
        word_odd <= pending_words[0].odd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare every strobed result with the oldest expected bin.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result bin=%0d value=%0h", bin_index, bin_value);
      end else begin
        bin_result_t e;
        e = expected_bins.pop_front();
        if (e.bin !== bin_index || e.value !== bin_value || e.last !== last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp bin=%0d value=%0h last=%0d, got bin=%0d value=%0h last=%0d",
                     e.bin, e.value, e.last, bin_index, bin_value, last_of_run);
        end
      end
    end
  end

  function automatic logic signed [31:0] random_word();
    case ($urandom_range(4))
      0: return 32'($urandom_range(255)) - 32'sd128;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($urandom_range(65535)) - 32'sd32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_directed();
    logic signed [31:0] corners[6];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1, 32'h5555_AAAA};
    foreach (corners[i]) pending_words.push_back('{8'd0, corners[i], corners[5 - i]});
    pending_words.push_back('{8'd1, 32'h8000_0000, 32'h8000_0000});
    pending_words.push_back('{8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_words.push_back('{8'd255, 32'sd0, 32'sd0});
    pending_words.push_back('{8'd128, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_words.push_back('{8'd200, -32'sd1, 32'sd1});
    pending_words.push_back('{8'd170, 32'sd0, 32'h8000_0000});
  endtask

  task automatic load_random(input int count);
    logic [7:0] p;
    repeat (count) begin
      p = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom);
      pending_words.push_back('{p, random_word(), random_word()});
    end
  endtask

  // Hold until every word is taken and every result is in, then let the
  // pipeline drain before touching configuration.
  task automatic wait_drained();
    while (pending_words.size() > 0 || start || expected_bins.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int idle_sched[4];
    idle_sched = '{0, 61, 0, 20};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Sweep all four mode combinations; reset values come first.
    for (int phase = 0; phase < 4; phase++) begin
      logic pm;
      logic lm;
      pm = (phase == 0 || phase == 3);
      lm = (phase >= 2);
      write_reg(REG_POWER_MODE, pm);
      write_reg(REG_LOG_MODE, lm);
      mode_power = pm;
      mode_log = lm;
      idle_pct = idle_sched[phase];
      load_directed();
      load_random(400);
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("[packed_fft_power_spectrum_top] OK");
    end else begin
      $display("[packed_fft_power_spectrum_top] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[packed_fft_power_spectrum_top] ERROR");
    $finish;
  end

endmodule
